@@ rtl/core/escape_time_fractal_pixel_core_defines.svh @@
// ----------------------------------------------------------------------------
// Escape-time fractal pixel core: assertion macros
// Shared assertion forms, clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ESCAPE_TIME_FRACTAL_PIXEL_CORE_DEFINES_SVH
`define ESCAPE_TIME_FRACTAL_PIXEL_CORE_DEFINES_SVH

// Property checked at every rising edge of clk_i outside reset
`define EFP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication outside reset
`define EFP_ASSERT_IMP(lbl, ante, cons, msg) \
  `EFP_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

// Next-cycle implication outside reset
`define EFP_ASSERT_NXT(lbl, ante, cons, msg) \
  `EFP_ASSERT_CLK(lbl, (ante) |=> (cons), msg)

`endif

@@ rtl/core/efp_pkg.sv @@
// ----------------------------------------------------------------------------
// Escape-time fractal pixel package
// Widths, fixed-point constants, colour weights and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package efp_pkg;

  // Fixed-point format: signed Q4.28
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PROD_W   = 64;
  localparam int unsigned SAT_IN_W = 66;
  localparam int unsigned Q_FRAC   = 28;

  // Field widths
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned CNT_OUT_W = 7;
  localparam int unsigned RED_W     = 7;
  localparam int unsigned GREEN_W   = 8;
  localparam int unsigned BLUE_W    = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_REAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_IMAG = 2'd1;

  // Escape bound: |s|^2 <= 4 in the full-width square domain (2^58)
  localparam logic [PROD_W-1:0] ESC_LIMIT = 64'h0400_0000_0000_0000;

  // 0.5 in Q4.28, widened for the saturation domain
  localparam logic signed [SAT_IN_W-1:0] POINT_FIVE = SAT_IN_W'(64'd1 << (Q_FRAC - 1));

  // Saturation bounds of the signed 32-bit range
  localparam logic signed [SAT_IN_W-1:0] SAT_HI =
    {{(SAT_IN_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic signed [SAT_IN_W-1:0] SAT_LO =
    {{(SAT_IN_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

  // Colour weights and quotient width (a quotient never exceeds its weight)
  localparam int unsigned COLOUR_K_W = 8;
  localparam int unsigned QUO_W      = 8;
  localparam logic [COLOUR_K_W-1:0] RED_K   = 8'd100;
  localparam logic [COLOUR_K_W-1:0] GREEN_K = 8'd195;
  localparam logic [COLOUR_K_W-1:0] BLUE_K  = 8'd220;

  // Sign-extend a product into the saturation domain
  function automatic logic signed [SAT_IN_W-1:0] sext_prod(input logic [PROD_W-1:0] p);
    return {{(SAT_IN_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // Sign-extend a data word into the saturation domain
  function automatic logic signed [SAT_IN_W-1:0] sext_data(input logic [DATA_W-1:0] d);
    return {{(SAT_IN_W-DATA_W){d[DATA_W-1]}}, d};
  endfunction

  // Clamp to the signed 32-bit range
  function automatic logic [DATA_W-1:0] sat_data(input logic signed [SAT_IN_W-1:0] v);
    logic [DATA_W-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/efp_mult.sv @@
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: shared multiplier
// One signed 32x32 multiply per cycle with the full 64-bit product registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efp_mult import efp_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic signed [DATA_W-1:0] a_i,
  input  wire logic signed [DATA_W-1:0] b_i,
  output logic             [PROD_W-1:0] p_o
);

  logic signed [PROD_W-1:0] prod;
  logic        [PROD_W-1:0] p_q;

  // Full signed product
  assign prod = a_i * b_i;

  // Register the product
  always_ff @(posedge clk_i) begin
    p_q <= prod;
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

@@ rtl/core/efp_cdiv.sv @@
// ----------------------------------------------------------------------------
// Escape-time fractal pixel: colour scale lane
// floor(count*weight/limit) by one multiply with a rounded-up reciprocal,
// registered on load.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module efp_cdiv import efp_pkg::*; #(
  parameter int unsigned           CNT_W = 7,
  parameter int unsigned           DEN   = 75,
  parameter logic [COLOUR_K_W-1:0] K     = 8'd100
) (
  input  wire logic             clk_i,
  input  wire logic             load_i,
  input  wire logic [CNT_W-1:0] cnt_i,
  output logic      [QUO_W-1:0] quo_o
);

  // A shift of twice the count width keeps the floor exact for every
  // count up to the limit, since the limit squared stays below 2^SHIFT
  localparam int unsigned SHIFT   = 2 * CNT_W;
  localparam int unsigned RECIP_W = SHIFT + COLOUR_K_W;
  localparam int unsigned SCALE_W = CNT_W + RECIP_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'(K) << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_WIDE[RECIP_W-1:0];

  logic [SCALE_W-1:0] scaled;
  logic [QUO_W-1:0]   quo_q, quo_d;

  // Count times the scaled weight over the limit
  assign scaled = SCALE_W'(cnt_i) * SCALE_W'(RECIP);

  // Take the quotient on load, hold it otherwise
  always_comb begin
    quo_d = quo_q;
    if (load_i) begin
      quo_d = scaled[SHIFT +: QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
  end

  assign quo_o = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/escape_time_fractal_pixel_core.sv @@
// ----------------------------------------------------------------------------
// Escape-time fractal pixel core
// Maps a pixel to a complex point c, iterates s = s*s + c in Q4.28 from the
// configured start point until escape or the iteration limit, and returns
// the count with a colour scaled from it.
//
//   channel  | control            | word
//   ---------+--------------------+---------------------------------------
//   pixel    | start_i / busy_o   | pixel_x_i, pixel_y_i
//   result   | done_o (strobe)    | out_x_o, out_y_o, iteration_count_o,
//            |                    | red_o, green_o, blue_o
//   config   | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// A pixel is taken in ST_IDLE, the next one in the cycle after done_o.
// Mapping runs in ST_MAP_R, ST_MAP_I and ST_MAP_C; each iteration takes
// three products on the single shared multiplier and the update ST_STEP;
// ST_DIV loads the reciprocal-multiply colour scale, ST_DONE strobes done_o.
// busy_o is high from the cycle after a pixel is taken until done_o falls.
// The result word is shown for one cycle only; the receiver cannot stall.
// Reset clears the start point to zero and returns the sequencer to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "escape_time_fractal_pixel_core_defines.svh"

module escape_time_fractal_pixel_core import efp_pkg::*; #(
  parameter int unsigned GRID_WIDTH     = 1000,
  parameter int unsigned GRID_HEIGHT    = 1000,
  parameter int unsigned MAX_ITERATIONS = 75
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // pixel channel
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [COORD_W-1:0]   pixel_x_i,
  input  wire logic [COORD_W-1:0]   pixel_y_i,
  // result channel
  output logic                      done_o,
  output logic      [COORD_W-1:0]   out_x_o,
  output logic      [COORD_W-1:0]   out_y_o,
  output logic      [CNT_OUT_W-1:0] iteration_count_o,
  output logic      [RED_W-1:0]     red_o,
  output logic      [GREEN_W-1:0]   green_o,
  output logic      [BLUE_W-1:0]    blue_o,
  // configuration port
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned CNT_W = $clog2(MAX_ITERATIONS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ITERATIONS);

  // Scale constants 2/W and 2/H in Q4.28, rounded
  localparam logic [63:0] KW_WIDE =
    ((64'd1 << 29) + 64'(GRID_WIDTH / 2)) / 64'(GRID_WIDTH);
  localparam logic [63:0] KH_WIDE =
    ((64'd1 << 29) + 64'(GRID_HEIGHT / 2)) / 64'(GRID_HEIGHT);
  localparam logic [DATA_W-1:0] KW      = KW_WIDE[DATA_W-1:0];
  localparam logic [DATA_W-1:0] KH      = KH_WIDE[DATA_W-1:0];
  localparam logic [DATA_W-1:0] GW_HALF = DATA_W'(GRID_WIDTH / 2);
  localparam logic [DATA_W-1:0] GH      = DATA_W'(GRID_HEIGHT);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_MAP_R  = 10'b00_0000_0010,
    ST_MAP_I  = 10'b00_0000_0100,
    ST_MAP_C  = 10'b00_0000_1000,
    ST_MUL_RR = 10'b00_0001_0000,
    ST_MUL_II = 10'b00_0010_0000,
    ST_MUL_RI = 10'b00_0100_0000,
    ST_STEP   = 10'b00_1000_0000,
    ST_DIV    = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [DATA_W-1:0]    start_re_q, start_im_q;
  logic [COORD_W-1:0]   px_q, py_q;
  logic [DATA_W-1:0]    re_q, re_d, im_q, im_d;
  logic [DATA_W-1:0]    cr_q, cr_d, ci_q, ci_d;
  logic [PROD_W-1:0]    rr_q, rr_d, ii_q, ii_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic        [PROD_W-1:0] prod;
  logic        [DATA_W-1:0] dx, dy;
  logic        [PROD_W-1:0] mag;
  logic                     stop;
  logic signed [SAT_IN_W-1:0] diff_rr_ii;
  logic                     div_load;
  logic [QUO_W-1:0]         red_quo, green_quo, blue_quo;
  logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

  // Start point registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_re_q <= '0;
      start_im_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_START_REAL) begin
        start_re_q <= cfg_wdata_i;
      end else if (cfg_idx_i == CFG_START_IMAG) begin
        start_im_q <= cfg_wdata_i;
      end
    end
  end

  // Offsets from the grid centre: x - W/2 and 2y - H
  assign dx = {{(DATA_W-COORD_W){1'b0}}, px_q} - GW_HALF;
  assign dy = {{(DATA_W-COORD_W-1){1'b0}}, py_q, 1'b0} - GH;

  // Operand select for the shared multiplier
  always_comb begin
    unique case (state_q)
      ST_MAP_R: begin
        mul_a = $signed(dx);
        mul_b = $signed(KW);
      end
      ST_MAP_I: begin
        mul_a = $signed(dy);
        mul_b = $signed(KH);
      end
      ST_MUL_RR: begin
        mul_a = $signed(re_q);
        mul_b = $signed(re_q);
      end
      ST_MUL_II: begin
        mul_a = $signed(im_q);
        mul_b = $signed(im_q);
      end
      default: begin
        mul_a = $signed(re_q);
        mul_b = $signed(im_q);
      end
    endcase
  end

  efp_mult u_mult (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Escape test on the two squares; the im*im product arrives in ST_MUL_RI
  assign mag        = rr_q + prod;
  assign stop       = (cnt_q == MAX_CNT) || (mag > ESC_LIMIT);
  assign diff_rr_ii = sext_prod(rr_q) - sext_prod(ii_q);

  // Sequencer and datapath update
  always_comb begin
    state_d   = state_q;
    re_d      = re_q;
    im_d      = im_q;
    cr_d      = cr_q;
    ci_d      = ci_q;
    rr_d      = rr_q;
    ii_d      = ii_q;
    cnt_d     = cnt_q;
    div_load  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          re_d    = start_re_q;
          im_d    = start_im_q;
          cnt_d   = '0;
          state_d = ST_MAP_R;
        end
      end
      ST_MAP_R: begin
        state_d = ST_MAP_I;
      end
      ST_MAP_I: begin
        cr_d    = sat_data(sext_prod(prod) - POINT_FIVE);
        state_d = ST_MAP_C;
      end
      ST_MAP_C: begin
        ci_d    = sat_data(sext_prod(prod) >>> 1);
        state_d = ST_MUL_RR;
      end
      ST_MUL_RR: begin
        state_d = ST_MUL_II;
      end
      ST_MUL_II: begin
        rr_d    = prod;
        state_d = ST_MUL_RI;
      end
      ST_MUL_RI: begin
        if (stop) begin
          state_d = ST_DIV;
        end else begin
          ii_d    = prod;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        re_d    = sat_data((diff_rr_ii >>> Q_FRAC) + sext_data(cr_q));
        im_d    = sat_data((sext_prod(prod) >>> (Q_FRAC - 1)) + sext_data(ci_q));
        cnt_d   = cnt_q + CNT_W'(1);
        state_d = ST_MUL_RR;
      end
      ST_DIV: begin
        div_load = 1'b1;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
    end
  end

  // Datapath registers; capture the pixel word on accept
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      px_q <= pixel_x_i;
      py_q <= pixel_y_i;
    end
    re_q <= re_d;
    im_q <= im_d;
    cr_q <= cr_d;
    ci_q <= ci_d;
    rr_q <= rr_d;
    ii_q <= ii_d;
  end

  // Colour lanes
  efp_cdiv #(.CNT_W(CNT_W), .DEN(MAX_ITERATIONS), .K(RED_K)) u_cdiv_red (
    .clk_i  (clk_i),
    .load_i (div_load),
    .cnt_i  (cnt_q),
    .quo_o  (red_quo)
  );

  efp_cdiv #(.CNT_W(CNT_W), .DEN(MAX_ITERATIONS), .K(GREEN_K)) u_cdiv_green (
    .clk_i  (clk_i),
    .load_i (div_load),
    .cnt_i  (cnt_q),
    .quo_o  (green_quo)
  );

  efp_cdiv #(.CNT_W(CNT_W), .DEN(MAX_ITERATIONS), .K(BLUE_K)) u_cdiv_blue (
    .clk_i  (clk_i),
    .load_i (div_load),
    .cnt_i  (cnt_q),
    .quo_o  (blue_quo)
  );

  // Result word, masked to the field widths
  assign cnt_ext           = {{CNT_OUT_W{1'b0}}, cnt_q};
  assign busy_o            = (state_q != ST_IDLE);
  assign done_o            = (state_q == ST_DONE);
  assign out_x_o           = px_q;
  assign out_y_o           = py_q;
  assign iteration_count_o = cnt_ext[CNT_OUT_W-1:0];
  assign red_o             = red_quo[RED_W-1:0];
  assign green_o           = green_quo[GREEN_W-1:0];
  assign blue_o            = blue_quo[BLUE_W-1:0];

  // Checks
  `EFP_ASSERT_NXT(a_accept_busy, start_i && !busy_o, busy_o && !done_o, "accept did not go busy")
  `EFP_ASSERT_NXT(a_done_single, done_o, !done_o && !busy_o, "result strobe not single")
  `EFP_ASSERT_IMP(a_cnt_bound, busy_o, cnt_q <= MAX_CNT, "iteration count beyond limit")
  `EFP_ASSERT_NXT(a_step_count, state_q == ST_STEP, cnt_q == $past(cnt_q) + CNT_W'(1), "step lost count")

endmodule

`default_nettype wire

@@ dv/tb_escape_time_fractal_pixel_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Escape-time fractal pixel core testbench
// Sends pixel words through the start/busy handshake and predicts each result
// word with an independent Q4.28 escape-time predictor. It checks every done
// strobe field by field against the oldest outstanding pixel. The start point
// registers are moved between phases, including the saturation extremes and
// the exact escape boundary. Writes to the spare register indexes must not
// disturb the start point.
// ----------------------------------------------------------------------------

module tb_escape_time_fractal_pixel_core;
  import efp_pkg::*;

  localparam int GRID_W           = 1000;
  localparam int GRID_H           = 1000;
  localparam int MAX_ITER         = 75;
  localparam int RANDOM_PHASES    = 15;
  localparam int PIXELS_PER_PHASE = 100;
  localparam int STALL_LIMIT      = 5000;
  localparam int TAIL_CYCLES      = 40;

  // Register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  // Bounds of the Q4.28 word
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [COORD_W-1:0]   y;
    logic [CNT_OUT_W-1:0] count;
    logic [RED_W-1:0]     red;
    logic [GREEN_W-1:0]   green;
    logic [BLUE_W-1:0]    blue;
  } pixel_result_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  logic [COORD_W-1:0]   pixel_x_i   = '0;
  logic [COORD_W-1:0]   pixel_y_i   = '0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = CFG_START_REAL;
  logic [DATA_W-1:0]    cfg_wdata_i = '0;
  logic                 busy_o;
  logic                 done_o;
  logic [COORD_W-1:0]   out_x_o;
  logic [COORD_W-1:0]   out_y_o;
  logic [CNT_OUT_W-1:0] iteration_count_o;
  logic [RED_W-1:0]     red_o;
  logic [GREEN_W-1:0]   green_o;
  logic [BLUE_W-1:0]    blue_o;

  // Predictor copy of the start point registers
  logic signed [DATA_W-1:0] start_re = '0;
  logic signed [DATA_W-1:0] start_im = '0;

  pixel_result_t pending_pixels[$];
  int unsigned   n_failures   = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   max_gap      = 16;

  escape_time_fractal_pixel_core #(
    .GRID_WIDTH    (GRID_W),
    .GRID_HEIGHT   (GRID_H),
    .MAX_ITERATIONS(MAX_ITER)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .pixel_x_i        (pixel_x_i),
    .pixel_y_i        (pixel_y_i),
    .done_o           (done_o),
    .out_x_o          (out_x_o),
    .out_y_o          (out_y_o),
    .iteration_count_o(iteration_count_o),
    .red_o            (red_o),
    .green_o          (green_o),
    .blue_o           (blue_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Clamp to the signed 32-bit range
  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  // Map the pixel to c and count steps of s = s*s + c until escape or limit
  function automatic pixel_result_t escape_pixel(input logic [COORD_W-1:0] px,
                                                 input logic [COORD_W-1:0] py);
    longint        kw, kh, cr, ci, re, im, rr, ii, ri, re_next;
    logic [PROD_W:0] mag;
    int unsigned   n;
    pixel_result_t r;
    kw = ((longint'(1) << 29) + GRID_W / 2) / GRID_W;
    kh = ((longint'(1) << 29) + GRID_H / 2) / GRID_H;
    cr = clamp_q((longint'(px) - GRID_W / 2) * kw - (longint'(1) << 27));
    ci = clamp_q(((2 * longint'(py) - GRID_H) * kh) >>> 1);
    re = start_re;
    im = start_im;
    n  = 0;
    forever begin
      rr  = re * re;
      ii  = im * im;
      ri  = re * im;
      // squares are never negative, so widen them unsigned
      mag = {1'b0, rr} + {1'b0, ii};
      if (n >= MAX_ITER || mag > {1'b0, ESC_LIMIT}) begin
        break;
      end
      re_next = clamp_q(((rr - ii) >>> Q_FRAC) + cr);
      im      = clamp_q((ri >>> (Q_FRAC - 1)) + ci);
      re      = re_next;
      n++;
    end
    r.x     = px;
    r.y     = py;
    r.count = CNT_OUT_W'(n);
    r.red   = RED_W'(n * RED_K / MAX_ITER);
    r.green = GREEN_W'(n * GREEN_K / MAX_ITER);
    r.blue  = BLUE_W'(n * BLUE_K / MAX_ITER);
    return r;
  endfunction

  // Mostly inside the grid, now and then just beyond it
  function automatic logic [COORD_W-1:0] random_coord(input int extent);
    if ($urandom_range(9) == 0) begin
      return COORD_W'($urandom_range((1 << COORD_W) - 1, extent));
    end
    return COORD_W'($urandom_range(extent - 1));
  endfunction

  // Offer one pixel word and hold it until the core takes it
  task automatic send_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
    int unsigned gap;
    bit          settle;
    gap    = $urandom_range(max_gap);
    settle = (max_gap != 0) && ($urandom_range(3) == 0);
    if (gap != 0 || settle) begin
      start_i <= 1'b0;
      if (settle) begin
        do @(posedge clk_i); while (busy_o);
      end
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    pixel_x_i <= x;
    pixel_y_i <= y;
    do @(posedge clk_i); while (busy_o);
    pending_pixels.push_back(escape_pixel(x, y));
  endtask

  // Drop start and wait for every outstanding result word
  task automatic drain_pixels();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_pixels.size() != 0);
  endtask

  // Write one register; the caller drops the write enable afterwards
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_START_REAL: start_re = data;
      CFG_START_IMAG: start_im = data;
      default: ;
    endcase
  endtask

  task automatic set_start_point(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
    drain_pixels();
    write_cfg(CFG_START_REAL, re);
    write_cfg(CFG_START_IMAG, im);
    cfg_we_i <= 1'b0;
  endtask

  // Grid corners, the centre, out-of-grid coordinates and alternating bits
  task automatic test_directed_pixels();
    logic [COORD_W-1:0] xs [11] = '{0, 999, 500, 1023, 1023, 0, 10'h2AA, 10'h155,
                                    250, 750, 500};
    logic [COORD_W-1:0] ys [11] = '{0, 999, 500, 1023, 0, 1023, 10'h155, 10'h2AA,
                                    500, 500, 0};
    max_gap = 16;
    foreach (xs[i]) begin
      send_pixel(xs[i], ys[i]);
    end
  endtask

  // Start points at the escape boundary and at the word extremes
  task automatic test_start_point_corners();
    logic [DATA_W-1:0] res [6] = '{32'h2000_0000, 32'h2000_0001, 32'h0000_0000,
                                   32'h7FFF_FFFF, 32'h8000_0000, 32'hE000_0000};
    logic [DATA_W-1:0] ims [6] = '{32'h0000_0000, 32'h0000_0000, 32'hE000_0000,
                                   32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000};
    foreach (res[i]) begin
      set_start_point(res[i], ims[i]);
      send_pixel(500, 500);
      send_pixel(random_coord(GRID_W), random_coord(GRID_H));
    end
  endtask

  // Writes to the spare indexes must leave the start point alone
  task automatic test_spare_register_writes();
    set_start_point(32'h0000_0000, 32'h0000_0000);
    write_cfg(CFG_SPARE_LO, $urandom());
    write_cfg(CFG_SPARE_HI, $urandom());
    cfg_we_i <= 1'b0;
    send_pixel(500, 500);
    send_pixel(0, 999);
  endtask

  // Phases of random pixels, each under a fresh start point
  task automatic test_random_pixels();
    logic [DATA_W-1:0] re, im;
    int unsigned       pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick = $urandom_range(9);
      if (pick < 6) begin
        re = int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
        im = int'($urandom_range(32'h4000_0000)) - 32'sh2000_0000;
      end else if (pick < 8) begin
        re = int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
        im = int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000;
      end else begin
        re = $urandom();
        im = $urandom();
      end
      // every third phase runs back to back
      max_gap = (phase % 3 == 2) ? 0 : 16;
      set_start_point(re, im);
      if ($urandom_range(3) == 0) begin
        write_cfg(CFG_SPARE_LO + CFG_IDX_W'($urandom_range(1)), $urandom());
        cfg_we_i <= 1'b0;
      end
      for (int i = 0; i < PIXELS_PER_PHASE; i++) begin
        send_pixel(random_coord(GRID_W), random_coord(GRID_H));
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_failures++;
    end
  endtask

  // Compare each result word with the oldest outstanding pixel
  always @(posedge clk_i) begin : check_results
    pixel_result_t want;
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        $error("result word for pixel (%0d, %0d) with no pixel outstanding", out_x_o, out_y_o);
        n_failures++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_x", want.x, out_x_o);
        check_field("out_y", want.y, out_y_o);
        check_field("iteration_count", want.count, iteration_count_o);
        check_field("red", want.red, red_o);
        check_field("green", want.green, green_o);
        check_field("blue", want.blue, blue_o);
      end
    end
  end

  // Stop a run in which no word moves for too long
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_pixels();
    test_start_point_corners();
    test_spare_register_writes();
    test_random_pixels();
    drain_pixels();
    // catch any stray result word after the last one
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (n_failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/efp_pkg.sv
rtl/core/efp_mult.sv
rtl/core/efp_cdiv.sv
rtl/core/escape_time_fractal_pixel_core.sv
dv/tb_escape_time_fractal_pixel_core.sv
